/* hdl/dttf_pkg.sv */
// Shared types, character codes and constants for the decimal text to fixed-point converter.
`default_nettype none
package dttf_pkg;

    localparam int unsigned COUNT_BITS  = 16;
    localparam int unsigned FRAC_DIGITS = 9;

    localparam int unsigned INT_W   = 31;
    localparam int unsigned FRAC_W  = 30;
    localparam int unsigned FD_W    = 4;
    localparam int unsigned QUO_W   = 32;
    localparam int unsigned STEP_W  = 5;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned OCNT_W  = 16;
    localparam int unsigned IN_W    = 8;
    localparam int unsigned OUT_W   = 88;

    localparam logic [INT_W-1:0]   INT_MAX   = {INT_W{1'b1}};
    localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    localparam logic [IN_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [IN_W-1:0] CH_NINE  = 8'h39;
    localparam logic [IN_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [IN_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [IN_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [IN_W-1:0] CH_SPACE = 8'h20;
    localparam logic [IN_W-1:0] CH_TAB   = 8'h09;
    localparam logic [IN_W-1:0] CH_LF    = 8'h0A;
    localparam logic [IN_W-1:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        ST_WS,
        ST_INT,
        ST_FRAC,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic is_digit;
        logic is_ws;
        logic is_sign;
        logic is_minus;
        logic is_dot;
    } char_class_t;

    typedef struct packed {
        logic take;
        logic int_digit;
        logic frac_digit;
        logic set_sign;
        logic terminate;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        char_class_t cls;
        logic        need_div;
        logic        div_last;
        logic        out_free;
    } dp_status_t;

    // 10^fd for the fraction scaling divide
    function automatic logic [FRAC_W-1:0] pow10(input logic [FD_W-1:0] fd);
        logic [FRAC_W-1:0] r;
        begin
            case (fd)
                4'd1:    r = 30'd10;
                4'd2:    r = 30'd100;
                4'd3:    r = 30'd1000;
                4'd4:    r = 30'd10000;
                4'd5:    r = 30'd100000;
                4'd6:    r = 30'd1000000;
                4'd7:    r = 30'd10000000;
                4'd8:    r = 30'd100000000;
                4'd9:    r = 30'd1000000000;
                default: r = 30'd1;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/dttf_ctrl.sv */
// Controller state machine: parse phases, fraction divide sequencing and result hand-off.
`default_nettype none
module dttf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire dttf_pkg::dp_status_t  status,
    output dttf_pkg::dp_cmd_t          cmd
);

    dttf_pkg::state_t state_reg;
    dttf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dttf_pkg::ST_WS;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            dttf_pkg::ST_WS:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.cls.is_ws)
                    begin
                        cmd.take = 1'b1;
                    end
                    else if (status.cls.is_sign)
                    begin
                        cmd.take     = 1'b1;
                        cmd.set_sign = 1'b1;
                        state_next   = dttf_pkg::ST_INT;
                    end
                    else if (status.cls.is_digit)
                    begin
                        cmd.take      = 1'b1;
                        cmd.int_digit = 1'b1;
                        state_next    = dttf_pkg::ST_INT;
                    end
                    else if (status.cls.is_dot)
                    begin
                        cmd.take   = 1'b1;
                        state_next = dttf_pkg::ST_FRAC;
                    end
                    else
                    begin
                        cmd.terminate = 1'b1;
                        state_next    = status.need_div ? dttf_pkg::ST_DIV : dttf_pkg::ST_DONE;
                    end
                end
            end
            dttf_pkg::ST_INT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.cls.is_digit)
                    begin
                        cmd.take      = 1'b1;
                        cmd.int_digit = 1'b1;
                    end
                    else if (status.cls.is_dot)
                    begin
                        cmd.take   = 1'b1;
                        state_next = dttf_pkg::ST_FRAC;
                    end
                    else
                    begin
                        cmd.terminate = 1'b1;
                        state_next    = status.need_div ? dttf_pkg::ST_DIV : dttf_pkg::ST_DONE;
                    end
                end
            end
            dttf_pkg::ST_FRAC:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.cls.is_digit)
                    begin
                        cmd.take       = 1'b1;
                        cmd.frac_digit = 1'b1;
                    end
                    else
                    begin
                        cmd.terminate = 1'b1;
                        state_next    = status.need_div ? dttf_pkg::ST_DIV : dttf_pkg::ST_DONE;
                    end
                end
            end
            dttf_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = dttf_pkg::ST_DONE;
                end
            end
            dttf_pkg::ST_DONE:
            begin
                // wait for the output register to free up
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = dttf_pkg::ST_WS;
                end
            end
            default:
            begin
                state_next = dttf_pkg::ST_WS;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hdl/dttf_dp.sv */
// Datapath: character decode, accumulators, bit-serial fraction divider and output register.
`default_nettype none
module dttf_dp #(
    parameter int unsigned COUNT_BITS = dttf_pkg::COUNT_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [dttf_pkg::IN_W-1:0]    char_code,
    input  wire dttf_pkg::dp_cmd_t            cmd,
    output dttf_pkg::dp_status_t              status,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic [dttf_pkg::VALUE_W-1:0]      value,
    output logic [dttf_pkg::OCNT_W-1:0]       consumed_count,
    output logic                              valid_res,
    output logic                              saturated
);

    localparam int unsigned EXT_W = COUNT_BITS + dttf_pkg::OCNT_W;
    localparam int unsigned NI_W  = dttf_pkg::INT_W + 4;
    localparam int unsigned NF_W  = dttf_pkg::FRAC_W + 4;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // parse accumulators
    logic                           negative_reg;
    logic [dttf_pkg::INT_W-1:0]     int_acc_reg;
    logic [dttf_pkg::FRAC_W-1:0]    frac_acc_reg;
    logic [dttf_pkg::FD_W-1:0]      frac_digits_reg;
    logic [COUNT_BITS-1:0]          char_count_reg;
    logic                           digit_seen_reg;
    logic                           clamp_reg;

    // divider
    logic [dttf_pkg::FRAC_W-1:0]    rem_reg;
    logic [dttf_pkg::FRAC_W-1:0]    divisor_reg;
    logic [dttf_pkg::QUO_W-1:0]     quo_reg;
    logic [dttf_pkg::STEP_W-1:0]    step_reg;

    // output register
    logic                           out_valid_reg;
    logic [dttf_pkg::VALUE_W-1:0]   value_reg;
    logic [dttf_pkg::OCNT_W-1:0]    ocount_reg;
    logic                           ovalid_res_reg;
    logic                           osat_reg;

    logic [3:0]                     digit;
    logic [NI_W-1:0]                int_next;
    logic [NF_W-1:0]                frac_next;
    logic [dttf_pkg::FRAC_W:0]      rem_shift;
    logic                           rem_ge;
    logic [dttf_pkg::VALUE_W-1:0]   mag;
    logic [dttf_pkg::VALUE_W-1:0]   signed_mag;
    logic [dttf_pkg::QUO_W-1:0]     frac_q;
    logic [EXT_W-1:0]               count_ext;
    logic [dttf_pkg::OCNT_W-1:0]    count_sat;

    always_comb
    begin
        status.cls.is_digit = (char_code >= dttf_pkg::CH_ZERO) && (char_code <= dttf_pkg::CH_NINE);
        status.cls.is_ws    = (char_code == dttf_pkg::CH_SPACE) || (char_code == dttf_pkg::CH_TAB) ||
                              (char_code == dttf_pkg::CH_LF)    || (char_code == dttf_pkg::CH_CR);
        status.cls.is_minus = (char_code == dttf_pkg::CH_MINUS);
        status.cls.is_sign  = status.cls.is_minus || (char_code == dttf_pkg::CH_PLUS);
        status.cls.is_dot   = (char_code == dttf_pkg::CH_DOT);
        status.need_div     = digit_seen_reg && !clamp_reg && (frac_digits_reg != '0);
        status.div_last     = (step_reg == {dttf_pkg::STEP_W{1'b1}});
        status.out_free     = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        digit     = char_code[3:0];
        int_next  = {int_acc_reg, 3'b000} + {2'b00, int_acc_reg, 1'b0} + NI_W'(digit);
        frac_next = {frac_acc_reg, 3'b000} + {2'b00, frac_acc_reg, 1'b0} + NF_W'(digit);
        rem_shift = {rem_reg, 1'b0};
        rem_ge    = rem_shift >= {1'b0, divisor_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            negative_reg    <= 1'b0;
            int_acc_reg     <= '0;
            frac_acc_reg    <= '0;
            frac_digits_reg <= '0;
            char_count_reg  <= '0;
            digit_seen_reg  <= 1'b0;
            clamp_reg       <= 1'b0;
        end
        else if (cmd.finish)
        begin
            negative_reg    <= 1'b0;
            int_acc_reg     <= '0;
            frac_acc_reg    <= '0;
            frac_digits_reg <= '0;
            char_count_reg  <= '0;
            digit_seen_reg  <= 1'b0;
            clamp_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.take && (char_count_reg != CNT_MAX))
            begin
                char_count_reg <= char_count_reg + 1'b1;
            end
            if (cmd.set_sign)
            begin
                negative_reg <= status.cls.is_minus;
            end
            if (cmd.int_digit)
            begin
                digit_seen_reg <= 1'b1;
                if (int_next > NI_W'(dttf_pkg::INT_MAX))
                begin
                    int_acc_reg <= dttf_pkg::INT_MAX;
                    clamp_reg   <= 1'b1;
                end
                else
                begin
                    int_acc_reg <= int_next[dttf_pkg::INT_W-1:0];
                end
            end
            if (cmd.frac_digit)
            begin
                digit_seen_reg <= 1'b1;
                if (frac_digits_reg < dttf_pkg::FD_W'(dttf_pkg::FRAC_DIGITS))
                begin
                    frac_acc_reg    <= frac_next[dttf_pkg::FRAC_W-1:0];
                    frac_digits_reg <= frac_digits_reg + 1'b1;
                end
            end
        end
    end

    // restoring divide of (frac << 32) by 10^fd, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.terminate)
        begin
            rem_reg     <= frac_acc_reg;
            divisor_reg <= dttf_pkg::pow10(frac_digits_reg);
            quo_reg     <= '0;
            step_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? rem_shift[dttf_pkg::FRAC_W-1:0] - divisor_reg
                               : rem_shift[dttf_pkg::FRAC_W-1:0];
            quo_reg  <= {quo_reg[dttf_pkg::QUO_W-2:0], rem_ge};
            step_reg <= step_reg + 1'b1;
        end
    end

    always_comb
    begin
        frac_q = (frac_digits_reg != '0) ? quo_reg : '0;
        if (clamp_reg)
        begin
            mag = dttf_pkg::VALUE_MAX;
        end
        else
        begin
            mag = {1'b0, int_acc_reg, frac_q};
        end
        signed_mag = negative_reg ? (dttf_pkg::VALUE_W'(0) - mag) : mag;
        count_ext  = EXT_W'(char_count_reg);
        count_sat  = (count_ext > EXT_W'({dttf_pkg::OCNT_W{1'b1}})) ? {dttf_pkg::OCNT_W{1'b1}}
                                                                    : count_ext[dttf_pkg::OCNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            value_reg      <= digit_seen_reg ? signed_mag : '0;
            ocount_reg     <= digit_seen_reg ? count_sat : '0;
            ovalid_res_reg <= digit_seen_reg;
            osat_reg       <= digit_seen_reg && clamp_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign value          = value_reg;
    assign consumed_count = ocount_reg;
    assign valid_res      = ovalid_res_reg;
    assign saturated      = osat_reg;

endmodule
`default_nettype wire

/* hdl/decimal_text_to_fixed_point_top.sv */
// The result is registered in ST_DONE after the terminator, via ST_DIV if the divide runs.
// The divide runs only for a converted, unsaturated number that has fraction digits.
// Within a string one character is taken per cycle; after the terminator input stalls
// while the 32-step fraction divider runs, then in ST_DONE until the output register is free.
// The next string's characters are taken while a result waits; a second terminator waits for it.
// rst_n (asynchronous, active low) clears the parser state and the output valid flag.
`default_nettype none
module decimal_text_to_fixed_point_top #(
    parameter int unsigned COUNT_BITS = dttf_pkg::COUNT_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,  // [7:0] char_code
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [63:0] value, [79:64] consumed_count, [80] valid_res, [81] saturated, [87:82] zero
    output logic [dttf_pkg::OUT_W-1:0]       m_axis_tdata
);

    dttf_pkg::dp_cmd_t    cmd;
    dttf_pkg::dp_status_t status;

    logic [dttf_pkg::VALUE_W-1:0] value;
    logic [dttf_pkg::OCNT_W-1:0]  consumed_count;
    logic                         valid_res;
    logic                         saturated;

    dttf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dttf_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_code      (s_axis_tdata),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .value          (value),
        .consumed_count (consumed_count),
        .valid_res      (valid_res),
        .saturated      (saturated)
    );

    assign m_axis_tdata = {6'd0, saturated, valid_res, consumed_count, value};

endmodule
`default_nettype wire

/* test/tb_decimal_text_to_fixed_point_top.sv */
// Testbench for decimal_text_to_fixed_point_top: character stream stimulus and result scoreboard.
`timescale 1ns / 100ps

module tb_decimal_text_to_fixed_point_top;

    localparam int unsigned IDLE_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_CHARS = 1360;

    // result word as it leaves the block, lowest field last
    typedef struct packed {
        logic [5:0]                   pad;
        logic                         saturated;
        logic                         valid_res;
        logic [dttf_pkg::OCNT_W-1:0]  consumed_count;
        logic [dttf_pkg::VALUE_W-1:0] value;
    } fixed_result_t;

    typedef enum logic [1:0] {
        SCAN_WS,
        SCAN_INT,
        SCAN_FRAC
    } scan_t;

    class fixed_point_scoreboard;
        scan_t                       scan;
        logic                        neg;
        logic [dttf_pkg::INT_W-1:0]  int_acc;
        logic [dttf_pkg::FRAC_W-1:0] frac_acc;
        logic [dttf_pkg::FD_W-1:0]   frac_n;
        int unsigned                 nchars;
        logic                        any_digit;
        logic                        clamped;
        int unsigned                 count_cap;
        fixed_result_t               pending[$];
        int unsigned                 errors;

        function new();
            longint unsigned cap;
            cap = (64'd1 << dttf_pkg::COUNT_BITS) - 1;
            count_cap = (cap > 65535) ? 65535 : int'(cap);
            errors = 0;
            clear();
        endfunction

        function void clear();
            scan = SCAN_WS;
            neg = 1'b0;
            int_acc = '0;
            frac_acc = '0;
            frac_n = '0;
            nchars = 0;
            any_digit = 1'b0;
            clamped = 1'b0;
        endfunction

        function logic [63:0] ten_pow(input logic [dttf_pkg::FD_W-1:0] n);
            logic [63:0] p;
            p = 64'd1;
            for (int i = 0; i < n; i++)
                p = p * 64'd10;
            return p;
        endfunction

        function void add_int(input logic [3:0] d);
            logic [63:0] next;
            next = {33'd0, int_acc} * 64'd10 + {60'd0, d};
            if (next > {33'd0, dttf_pkg::INT_MAX}) begin
                int_acc = dttf_pkg::INT_MAX;
                clamped = 1'b1;
            end else begin
                int_acc = next[dttf_pkg::INT_W-1:0];
            end
            any_digit = 1'b1;
        endfunction

        function void add_frac(input logic [3:0] d);
            if (frac_n < dttf_pkg::FRAC_DIGITS && frac_n < 9) begin
                frac_acc = frac_acc * 30'd10 + {26'd0, d};
                frac_n = frac_n + 1'b1;
            end
            any_digit = 1'b1;
        endfunction

        // one accepted character; a terminator queues the expected result
        function void note_char(input logic [7:0] c);
            logic is_digit, is_ws, is_sign, taken;
            logic [3:0] d;
            fixed_result_t r;
            logic [63:0] fq, mag;
            is_digit = (c >= dttf_pkg::CH_ZERO) && (c <= dttf_pkg::CH_NINE);
            is_ws = (c == dttf_pkg::CH_SPACE) || (c == dttf_pkg::CH_TAB) ||
                    (c == dttf_pkg::CH_LF) || (c == dttf_pkg::CH_CR);
            is_sign = (c == dttf_pkg::CH_PLUS) || (c == dttf_pkg::CH_MINUS);
            d = c[3:0];
            taken = 1'b0;
            case (scan)
                SCAN_WS:
                begin
                    if (is_ws) begin
                        taken = 1'b1;
                    end else if (is_sign) begin
                        neg = (c == dttf_pkg::CH_MINUS);
                        scan = SCAN_INT;
                        taken = 1'b1;
                    end else if (is_digit) begin
                        add_int(d);
                        scan = SCAN_INT;
                        taken = 1'b1;
                    end else if (c == dttf_pkg::CH_DOT) begin
                        scan = SCAN_FRAC;
                        taken = 1'b1;
                    end
                end
                SCAN_INT:
                begin
                    if (is_digit) begin
                        add_int(d);
                        taken = 1'b1;
                    end else if (c == dttf_pkg::CH_DOT) begin
                        scan = SCAN_FRAC;
                        taken = 1'b1;
                    end
                end
                default:
                begin
                    if (is_digit) begin
                        add_frac(d);
                        taken = 1'b1;
                    end
                end
            endcase
            if (taken) begin
                if (nchars < count_cap)
                    nchars++;
                return;
            end
            r = '0;
            if (any_digit) begin
                if (clamped) begin
                    mag = dttf_pkg::VALUE_MAX;
                end else begin
                    fq = '0;
                    if (frac_n > 0)
                        fq = ({34'd0, frac_acc} << 32) / ten_pow(frac_n);
                    mag = {1'b0, int_acc, 32'd0} | {32'd0, fq[31:0]};
                end
                if (neg)
                    mag = -mag;
                r.value = mag;
                r.consumed_count = nchars[dttf_pkg::OCNT_W-1:0];
                r.valid_res = 1'b1;
                r.saturated = clamped;
            end
            pending.push_back(r);
            clear();
        endfunction

        function void check_result(input logic [dttf_pkg::OUT_W-1:0] raw);
            fixed_result_t got, want;
            got = raw;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, raw);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value) begin
                $display("%0t: value mismatch, expected %h, actual %h",
                         $time, want.value, got.value);
                errors++;
            end
            if (got.consumed_count !== want.consumed_count) begin
                $display("%0t: consumed_count mismatch, expected %0d, actual %0d",
                         $time, want.consumed_count, got.consumed_count);
                errors++;
            end
            if (got.valid_res !== want.valid_res) begin
                $display("%0t: valid_res mismatch, expected %b, actual %b",
                         $time, want.valid_res, got.valid_res);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $display("%0t: saturated mismatch, expected %b, actual %b",
                         $time, want.saturated, got.saturated);
                errors++;
            end
            if (got.pad !== want.pad) begin
                $display("%0t: pad bits mismatch, expected %h, actual %h",
                         $time, want.pad, got.pad);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [dttf_pkg::OUT_W-1:0] m_axis_tdata;

    fixed_point_scoreboard sb = new();
    int unsigned chars_sent = 0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    bit hold_req = 1'b0;

    always #5 clk = ~clk;

    decimal_text_to_fixed_point_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // offer one character and wait for its transfer; gaps fall between bursts
    task automatic send_char(input logic [7:0] c);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 7) == 0 ? $urandom_range(8, 40) : $urandom_range(1, 4))
                @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_digits(input int unsigned n);
        repeat (n)
            send_char(dttf_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // mostly well-formed numbers with random content, some raw noise
    task automatic send_number();
        logic [7:0] ws_set[4];
        ws_set = '{dttf_pkg::CH_SPACE, dttf_pkg::CH_TAB, dttf_pkg::CH_LF, dttf_pkg::CH_CR};
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8))
                send_char(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2))
            send_char(ws_set[$urandom_range(0, 3)]);
        case ($urandom_range(0, 2))
            1: send_char(dttf_pkg::CH_PLUS);
            2: send_char(dttf_pkg::CH_MINUS);
            default: ;
        endcase
        send_digits(($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6));
        if ($urandom_range(0, 1) == 1) begin
            send_char(dttf_pkg::CH_DOT);
            send_digits($urandom_range(0, 12));
        end
        send_char(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
    endtask

    // receiver: changing stall patterns, plus one long hold-off
    initial begin
        int unsigned mode, mode_left, phase_cnt;
        mode = 0;
        mode_left = 50;
        phase_cnt = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= ($urandom_range(0, 4) == 0);
                    default: m_axis_tready <= (phase_cnt % 4 != 3);
                endcase
                phase_cnt++;
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
            end
        end
    end

    // result monitor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL decimal_text_to_fixed_point_top");
                $finish;
            end
        end
    end

    initial begin
        int unsigned random_end;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // whitespace of every kind, negative zero, top byte as terminator
        send_char(dttf_pkg::CH_TAB);
        send_char(dttf_pkg::CH_LF);
        send_char(dttf_pkg::CH_CR);
        send_text(" -0");
        send_char(8'hFF);
        // integer overflow then a sign after a digit
        send_text("-9999999999+");
        // sign with dot, NUL terminator
        send_text("+.");
        send_char(8'h00);
        // lone dot, lone sign ended by whitespace, second dot, extra fraction digits
        send_text(".x- 1.2..0123456789 ");

        hold_req = 1'b1;
        random_end = chars_sent + RANDOM_CHARS;
        while (chars_sent < random_end)
            send_number();
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS decimal_text_to_fixed_point_top");
        else
            $display("FAIL decimal_text_to_fixed_point_top");
        $finish;
    end

endmodule

/* filelist.f */
hdl/dttf_pkg.sv
hdl/dttf_ctrl.sv
hdl/dttf_dp.sv
hdl/decimal_text_to_fixed_point_top.sv
test/tb_decimal_text_to_fixed_point_top.sv
